// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define NPI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("npi assertion failed");

// clocked assertion, also checked during reset
`define NPI_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("npi assertion failed");

`endif

// ----- hw/rtl/npi_pkg.sv -----
`default_nettype none

package npi_pkg;

   localparam int COLOR_W = 8;
   localparam int DIST_W = 18;

   localparam int WEIGHT_RED = 299;
   localparam int WEIGHT_GREEN = 587;
   localparam int WEIGHT_BLUE = 114;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic bright;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/npi_ram.sv -----
`default_nettype none

module npi_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_palette_index.sv -----
`default_nettype none

// channel   ports                         handshake
// request   start, busy, req_*            beat taken when start && !busy
// response  rsp_valid, rsp_*              beat lives one cycle, always taken
//
// A load beat keeps busy high while it reads the old entry and then writes
// the new one. A pixel beat keeps busy high while it scans the palette:
// one palette memory read per cycle, then a distance stage and a compare
// stage drain. After reset the palette memory is cleared, one entry a cycle,
// with busy high until every entry has been written.
// The response strobe rises in the last busy cycle; it cannot be stalled.

module nearest_palette_index #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_kind,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_entry_index,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_entry_red,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_entry_green,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_entry_blue,
   input  wire logic                        req_entry_is_bright,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_base_red,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_base_green,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_base_blue,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_glow_red,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_glow_green,
   input  wire logic [npi_pkg::COLOR_W-1:0] req_glow_blue,
   output logic                             rsp_valid,
   output logic      [npi_pkg::COLOR_W-1:0] rsp_colour_index,
   output logic                             rsp_no_candidate
);

   import npi_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int IW = ((AW > COLOR_W) ? AW : COLOR_W) + 1;
   localparam int CW = $clog2(PALETTE_ENTRIES + 1);
   localparam int EW = $bits(entry_type);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [AW-1:0] ctr_ff, ctr_in;
   logic [CW-1:0] bright_count_ff, bright_count_in;
   logic rd_valid_ff, rd_valid_in;
   logic dist_valid_ff, dist_valid_in;
   logic found_ff, found_in;

   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] dist_idx_ff, dist_idx_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic dist_qual_ff, dist_qual_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [COLOR_W-1:0] tgt_red_ff, tgt_red_in;
   logic [COLOR_W-1:0] tgt_green_ff, tgt_green_in;
   logic [COLOR_W-1:0] tgt_blue_ff, tgt_blue_in;
   logic want_bright_ff, want_bright_in;
   logic [AW-1:0] ld_addr_ff, ld_addr_in;
   entry_type ld_entry_ff, ld_entry_in;
   logic ld_ok_ff, ld_ok_in;

   logic ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   entry_type rd_entry;
   logic [IW-1:0] slot_wide;
   logic [IW-1:0] best_wide;
   logic accept;
   logic glow_on;
   logic [COLOR_W-1:0] dr, dg, db;

   npi_ram #(
      .WIDTH(EW),
      .DEPTH(PALETTE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign slot_wide = IW'(req_entry_index);
   assign best_wide = IW'(best_idx_ff);
   assign accept = start && !busy;
   assign glow_on = (req_glow_red != '0) || (req_glow_green != '0) || (req_glow_blue != '0);

   assign dr = abs_diff(rd_entry.red, tgt_red_ff);
   assign dg = abs_diff(rd_entry.green, tgt_green_ff);
   assign db = abs_diff(rd_entry.blue, tgt_blue_ff);

   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      bright_count_in = bright_count_ff;
      rd_valid_in = 1'b0;
      rd_idx_in = ctr_ff;
      dist_valid_in = rd_valid_ff;
      dist_idx_in = rd_idx_ff;
      dist_qual_in = (rd_entry.bright == want_bright_ff);
      dist_in = DIST_W'(WEIGHT_RED) * DIST_W'(dr)
              + DIST_W'(WEIGHT_GREEN) * DIST_W'(dg)
              + DIST_W'(WEIGHT_BLUE) * DIST_W'(db);
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_dist_in = best_dist_ff;
      tgt_red_in = tgt_red_ff;
      tgt_green_in = tgt_green_ff;
      tgt_blue_in = tgt_blue_ff;
      want_bright_in = want_bright_ff;
      ld_addr_in = ld_addr_ff;
      ld_entry_in = ld_entry_ff;
      ld_ok_in = ld_ok_ff;

      ram_wr_en = 1'b0;
      ram_wr_addr = ld_addr_ff;
      ram_wr_data = EW'(ld_entry_ff);
      ram_rd_addr = ld_addr_ff;

      busy = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      rsp_colour_index = found_ff ? best_wide[COLOR_W-1:0] : '0;
      rsp_no_candidate = !found_ff;

      if (dist_valid_ff && dist_qual_ff && (!found_ff || dist_ff < best_dist_ff)) begin
         found_in = 1'b1;
         best_idx_in = dist_idx_ff;
         best_dist_in = dist_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = ctr_ff;
            ram_wr_data = '0;
            ctr_in = ctr_ff + AW'(1);
            if (ctr_ff == LAST_ADDR) begin
               ctr_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  ld_addr_in = slot_wide[AW-1:0];
                  ld_ok_in = (slot_wide < IW'(PALETTE_ENTRIES));
                  ld_entry_in = '{red: req_entry_red, green: req_entry_green,
                                  blue: req_entry_blue, bright: req_entry_is_bright};
                  state_in = ST_LOAD_RD;
               end else begin
                  if (glow_on) begin
                     tgt_red_in = req_glow_red;
                     tgt_green_in = req_glow_green;
                     tgt_blue_in = req_glow_blue;
                     want_bright_in = (bright_count_ff != '0);
                  end else begin
                     tgt_red_in = req_base_red;
                     tgt_green_in = req_base_green;
                     tgt_blue_in = req_base_blue;
                     want_bright_in = 1'b0;
                  end
                  found_in = 1'b0;
                  ctr_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            ram_wr_en = ld_ok_ff;
            if (ld_ok_ff) begin
               priority if (rd_entry.bright && !ld_entry_ff.bright) begin
                  bright_count_in = bright_count_ff - CW'(1);
               end else if (!rd_entry.bright && ld_entry_ff.bright) begin
                  bright_count_in = bright_count_ff + CW'(1);
               end else begin
                  bright_count_in = bright_count_ff;
               end
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            ram_rd_addr = ctr_ff;
            rd_valid_in = 1'b1;
            ctr_in = ctr_ff + AW'(1);
            if (ctr_ff == LAST_ADDR) begin
               ctr_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_valid_ff) begin
               rsp_valid = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ctr_ff <= '0;
         bright_count_ff <= '0;
         rd_valid_ff <= 1'b0;
         dist_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         bright_count_ff <= bright_count_in;
         rd_valid_ff <= rd_valid_in;
         dist_valid_ff <= dist_valid_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      dist_idx_ff <= dist_idx_in;
      dist_ff <= dist_in;
      dist_qual_ff <= dist_qual_in;
      best_idx_ff <= best_idx_in;
      best_dist_ff <= best_dist_in;
      tgt_red_ff <= tgt_red_in;
      tgt_green_ff <= tgt_green_in;
      tgt_blue_ff <= tgt_blue_in;
      want_bright_ff <= want_bright_in;
      ld_addr_ff <= ld_addr_in;
      ld_entry_ff <= ld_entry_in;
      ld_ok_ff <= ld_ok_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/npi_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module npi_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        req_kind,
   input wire logic                        rsp_valid,
   input wire logic [npi_pkg::COLOR_W-1:0] rsp_colour_index,
   input wire logic                        rsp_no_candidate
);

   import npi_pkg::*;

   `NPI_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> busy)
   `NPI_ASSERT_ALWAYS(a_rsp_while_busy, clock, rsp_valid |-> busy)
   `NPI_ASSERT_ALWAYS(a_rsp_single, clock, rsp_valid |=> !rsp_valid)
   `NPI_ASSERT(a_load_no_rsp, clock, reset,
      (start && !busy && req_kind == KIND_LOAD) |=> (busy && !rsp_valid))
   `NPI_ASSERT_ALWAYS(a_none_index_zero, clock,
      (rsp_valid && rsp_no_candidate) |-> (rsp_colour_index == '0))

endmodule

bind nearest_palette_index npi_checker u_npi_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_colour_index(rsp_colour_index),
   .rsp_no_candidate(rsp_no_candidate)
);

`default_nettype wire
